FILE: hw/rtl/bba_pkg.sv
// Package for the block bitmap allocator: payload structs, status codes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int BLK_W      = 16;
    localparam int CNT_W      = 17;
    localparam int ROW_BITS   = 64;
    localparam int ROW_LOG    = 6;
    localparam int ADDR_LIMIT = 65536;

    localparam logic [CNT_W-1:0] CNT_RESET = 17'h10000;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type        req_type;
        logic [BLK_W-1:0] block_number;
    } t_request;

    typedef struct packed {
        logic [BLK_W-1:0] result_block;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    scan_next;
        logic    latch_row;
        logic    alloc_commit;
        logic    free_commit;
        logic    set_res;
        t_status res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic req_free;
        logic range_err;
        logic clr_last;
        logic sum_has_zero;
        logic sum_beyond;
        logic sum_last;
        logic blk_beyond;
        logic bit_used;
    } t_dp_stat;

endpackage

FILE: hw/rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bba_dp.sv
// Allocator datapath: bitmap RAM (64 blocks per row), row-full summary RAM,
// request/result registers and the count register. Depends on bba_pkg, bba_ram.
`timescale 1ns / 1ps

module bba_dp import bba_pkg::*; #(
    parameter int MAX_BLOCKS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  t_request         i_req,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output t_result          o_result
);

    localparam int EFF       = (MAX_BLOCKS > ADDR_LIMIT) ? ADDR_LIMIT : MAX_BLOCKS;
    localparam int ROWS      = (EFF + ROW_BITS - 1) / ROW_BITS;
    localparam int SUM_WORDS = (ROWS + ROW_BITS - 1) / ROW_BITS;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW        = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

    localparam logic [CNT_W-1:0] EFF_CNT = CNT_W'(EFF);

    function automatic logic [ROW_LOG-1:0] first_zero(input logic [ROW_BITS-1:0] w);
        logic [ROW_LOG-1:0] idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = ROW_LOG'(i);
            end
        end
        return idx;
    endfunction

    logic [CNT_W-1:0]    r_total;
    logic [RW-1:0]       r_clr_idx;
    logic                r_req_free;
    logic [BLK_W-1:0]    r_blk;
    logic [RW-1:0]       r_row;
    logic [SW-1:0]       r_sidx;
    logic [ROW_LOG-1:0]  r_sbit;
    t_result             r_result;

    logic [ROW_BITS-1:0] d_rdata, d_wdata, s_rdata, s_wdata;
    logic [ROW_BITS-1:0] d_amask, d_fmask, s_mask, d_new;
    logic [RW-1:0]       d_waddr;
    logic [SW-1:0]       s_waddr;
    logic                d_we, s_we;
    logic [CNT_W-1:0]    count, sum_base;
    logic [ROW_LOG-1:0]  fz_sum, fz_dat;
    logic [SW+ROW_LOG-1:0] row_cand;
    logic [BLK_W-1:0]    alloc_blk;

    assign count     = (r_total > EFF_CNT) ? EFF_CNT : r_total;
    assign fz_sum    = first_zero(s_rdata);
    assign fz_dat    = first_zero(d_rdata);
    assign row_cand  = {r_sidx, fz_sum};
    assign sum_base  = CNT_W'({row_cand, {ROW_LOG{1'b0}}});
    assign alloc_blk = BLK_W'({r_sidx, r_sbit, fz_dat});
    assign d_amask   = ROW_BITS'(1) << fz_dat;
    assign d_fmask   = ROW_BITS'(1) << r_blk[ROW_LOG-1:0];
    assign s_mask    = ROW_BITS'(1) << r_sbit;
    assign d_new     = d_rdata | d_amask;

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_row;
        d_wdata = d_new;
        s_we    = 1'b0;
        s_waddr = r_sidx;
        s_wdata = s_rdata | s_mask;
        if (i_cmd.clr_step) begin
            d_we    = 1'b1;
            d_waddr = r_clr_idx;
            d_wdata = '0;
            s_we    = ({1'b0, r_clr_idx} < (RW+1)'(SUM_WORDS));
            s_waddr = r_clr_idx[SW-1:0];
            s_wdata = '0;
        end else if (i_cmd.alloc_commit) begin
            d_we = 1'b1;
            s_we = &d_new;      // row just filled up
        end else if (i_cmd.free_commit) begin
            d_we    = 1'b1;
            d_wdata = d_rdata & ~d_fmask;
            s_we    = 1'b1;
            s_wdata = s_rdata & ~s_mask;
        end
    end

    bba_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (r_row),
        .o_rdata (d_rdata)
    );

    bba_ram #(.WIDTH(ROW_BITS), .DEPTH(SUM_WORDS)) u_summary (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_sidx),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= CNT_RESET;
            r_clr_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_free <= (i_req.req_type == REQ_FREE);
            r_blk      <= i_req.block_number;
            r_row      <= i_req.block_number[ROW_LOG +: RW];
            r_sbit     <= i_req.block_number[ROW_LOG +: ROW_LOG];
            r_sidx     <= (i_req.req_type == REQ_FREE) ?
                          i_req.block_number[2*ROW_LOG +: SW] : '0;
        end
        if (i_cmd.scan_next) begin
            r_sidx <= r_sidx + 1'b1;
        end
        if (i_cmd.latch_row) begin
            r_row  <= row_cand[RW-1:0];
            r_sbit <= fz_sum;
        end
        if (i_cmd.set_res) begin
            r_result.status <= i_cmd.res_code;
            if (i_cmd.res_code == ST_FULL) begin
                r_result.result_block <= '0;
            end else if (r_req_free) begin
                r_result.result_block <= r_blk;
            end else begin
                r_result.result_block <= alloc_blk;
            end
        end
    end

    assign o_stat.req_free     = r_req_free;
    assign o_stat.range_err    = ({1'b0, r_blk} >= count);
    assign o_stat.clr_last     = (r_clr_idx == RW'(ROWS - 1));
    assign o_stat.sum_has_zero = ~&s_rdata;
    assign o_stat.sum_beyond   = (sum_base >= count);
    assign o_stat.sum_last     = (r_sidx == SW'(SUM_WORDS - 1));
    assign o_stat.blk_beyond   = ({1'b0, alloc_blk} >= count);
    assign o_stat.bit_used     = d_rdata[r_blk[ROW_LOG-1:0]];

    assign o_result = r_result;

endmodule

FILE: hw/rtl/bba_ctrl.sv
// Allocator controller: one-hot sequencer for clear pass, summary scan,
// allocate and free. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_DRD   = 8'b0001_0000,
        S_ALLOC = 8'b0010_0000,
        S_CHK   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_code = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                // RAM addresses are presented in this cycle
                if (i_stat.req_free && i_stat.range_err) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_RANGE;
                    n_state        = S_DONE;
                end else if (i_stat.req_free) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.sum_has_zero) begin
                    if (i_stat.sum_beyond) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_FULL;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.latch_row = 1'b1;
                        n_state         = S_DRD;
                    end
                end else if (i_stat.sum_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FULL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_DRD: begin
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.set_res = 1'b1;
                if (i_stat.blk_beyond) begin
                    o_cmd.res_code = ST_FULL;
                end else begin
                    o_cmd.alloc_commit = 1'b1;
                    o_cmd.res_code     = ST_OK;
                end
                n_state = S_DONE;
            end
            S_CHK: begin
                o_cmd.set_res = 1'b1;
                if (i_stat.bit_used) begin
                    o_cmd.free_commit = 1'b1;
                    o_cmd.res_code    = ST_OK;
                end else begin
                    o_cmd.res_code = ST_ALREADY_FREE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

FILE: hw/rtl/block_bitmap_allocator.sv
// Top level of the first-fit disk block allocator.
// Depends on bba_pkg, bba_ctrl, bba_dp (which holds two bba_ram instances).
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive i_req and raise start; the transaction is taken at
//   a clock edge where start is high and busy is low. req_type selects
//   allocate or free; block_number is only used by a free.
//   Result channel: o_valid is high for exactly one cycle with o_result;
//   the receiver cannot stall, so it must take the result in that cycle.
//   Configuration: i_cfg_we with i_cfg_wdata writes total_blocks. The user must
//   write it only while the block is idle (busy low, no result pending); the
//   block itself does not enforce this.
//   Sequence after the accepting edge: a free out of range is rejected in the
//   read state; other frees check the bit and clear it if set. An allocate reads
//   summary words (64 rows, 4096 blocks each) until one shows a usable row or
//   the last is read, then that bitmap row. busy drops the cycle after o_valid.
//   One transaction at a time; the summary RAM scan sets the time.
//   Reset: synchronous, active low. Afterwards the bitmap and summary RAMs are
//   swept to all free, one 64-block row per cycle, with busy high meanwhile;
//   the bitmap has ceil(min(MAX_BLOCKS,65536) / 64) rows (1024 at the default).
//   total_blocks resets to 65536.
module block_bitmap_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_request         i_req,
    output logic             o_valid,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    bba_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not make the block busy");

    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_res |=> o_valid)
        else $error("recorded result not presented");

endmodule

FILE: dv/block_bitmap_allocator_tb.sv
// Self-checking testbench for block_bitmap_allocator: first-fit allocate and free
// requests are checked against a bitmap predictor across several block counts.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
    import bba_pkg::*;

    localparam int MAX_BLK   = 65536;
    localparam int WD_LIMIT  = 20000;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 86;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_request         i_req       = '0;
    logic             o_valid;
    t_result          o_result;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;

    // predictor state
    bit [MAX_BLK-1:0] usage_map;
    logic [CNT_W-1:0] blocks_cfg = CNT_RESET;

    t_request    request_q[$];
    t_result     pending_results[$];
    int unsigned idle_pct     = 0;
    int unsigned n_errors     = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_allocated  = 0;
    int unsigned n_full       = 0;
    int unsigned n_dbl_free   = 0;
    int unsigned n_range      = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned wd_count     = 0;

    block_bitmap_allocator #(.MAX_BLOCKS(MAX_BLK)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // First-fit allocate / checked free against the local bitmap.
    function automatic t_result predict_block_result(t_request rq);
        int unsigned lim;
        t_result     r;
        lim = (blocks_cfg > ADDR_LIMIT) ? ADDR_LIMIT : int'(blocks_cfg);
        if (lim > MAX_BLK) lim = MAX_BLK;
        r.result_block = rq.block_number;
        r.status       = ST_OK;
        if (rq.req_type == REQ_ALLOC) begin
            r.result_block = '0;
            r.status       = ST_FULL;
            for (int b = 0; b < lim; b++) begin
                if (!usage_map[b]) begin
                    usage_map[b]   = 1'b1;
                    r.result_block = b[BLK_W-1:0];
                    r.status       = ST_OK;
                    break;
                end
            end
        end else if (rq.block_number >= lim) begin
            r.status = ST_RANGE;
        end else if (!usage_map[rq.block_number]) begin
            r.status = ST_ALREADY_FREE;
        end else begin
            usage_map[rq.block_number] = 1'b0;
        end
        return r;
    endfunction

    // Driver: offers queued requests, predicts each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            usage_map  = '0;
            blocks_cfg = CNT_RESET;
            start <= 1'b0;
        end else begin
            if (i_cfg_we) blocks_cfg = i_cfg_wdata;
            if (start && !busy) begin
                pending_results.push_back(predict_block_result(i_req));
                n_accepted++;
            end
            if (!start || !busy) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_req <= request_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_block %0d status %0d",
                       o_result.result_block, o_result.status);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result.result_block !== exp_res.result_block) begin
                    $error("result_block: expected %0d, got %0d",
                           exp_res.result_block, o_result.result_block);
                    n_errors++;
                end
                if (o_result.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_res.status, o_result.status);
                    n_errors++;
                end
                case (o_result.status)
                    ST_FULL:         n_full++;
                    ST_ALREADY_FREE: n_dbl_free++;
                    ST_RANGE:        n_range++;
                    default:         n_allocated++;
                endcase
            end
        end
    end

    // Watchdog: cycles with neither an accepted request nor a result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", wd_count);
            $display("simulation failed");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    function automatic void queue_request(t_req_type rt, logic [BLK_W-1:0] blk);
        t_request rq;
        rq.req_type     = rt;
        rq.block_number = blk;
        request_q.push_back(rq);
    endfunction

    // Slightly more allocations than frees; frees mostly of low blocks (where first
    // fit puts allocations), some up to just past the count, top or fully random.
    function automatic void queue_random_requests(int n, int unsigned lim);
        int unsigned      r;
        int unsigned      hi;
        logic [BLK_W-1:0] blk;
        hi = (lim == 0) ? 7 : ((lim + 2 > 65535) ? 65535 : lim + 2);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      blk = BLK_W'($urandom_range(0, 63));
            else if (r < 80) blk = BLK_W'($urandom_range(0, hi));
            else if (r < 90) blk = BLK_W'(65535 - $urandom_range(0, 3));
            else             blk = BLK_W'($urandom());
            if ($urandom_range(0, 99) < 52) queue_request(REQ_ALLOC, BLK_W'($urandom()));
            else                            queue_request(REQ_FREE, blk);
        end
    endfunction

    // Hold the sender until the block is idle with nothing outstanding.
    // Sampled on the falling edge so that the driver's updates have settled.
    task automatic drain_requests();
        while (request_q.size() != 0 || start || pending_results.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic write_block_count(logic [CNT_W-1:0] v);
        drain_requests();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        n_cfg_writes++;
    endtask

    initial begin
        logic [CNT_W-1:0] cfg_val;
        int unsigned      lim;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: in-order reservation after reset, double free, top block
        idle_pct = 0;
        queue_request(REQ_ALLOC, 16'hFFFF);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_ALLOC, 16'h5A5A);
        queue_request(REQ_FREE, 16'd1);
        queue_request(REQ_FREE, 16'd1);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_FREE, 16'hFFFF);
        queue_request(REQ_FREE, 16'd0);
        queue_request(REQ_ALLOC, 16'hFFFF);
        // zero count: everything full or out of range
        write_block_count('0);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_FREE, 16'd0);
        queue_request(REQ_FREE, 16'hFFFF);
        // shrunk count of one: block 0 still used from before
        write_block_count(17'd1);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_FREE, 16'd0);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_FREE, 16'd1);
        // largest register value clamps to the address space
        write_block_count(17'h1FFFF);
        queue_request(REQ_ALLOC, 16'h0000);
        queue_request(REQ_FREE, 16'd65535);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       cfg_val = 17'd3;
                1:       cfg_val = 17'd65535;
                2:       cfg_val = 17'd17;
                3:       cfg_val = 17'd0;
                4:       cfg_val = 17'd64;
                5:       cfg_val = 17'h1FFFF;
                6:       cfg_val = 17'd200;
                7:       cfg_val = 17'd65;
                8:       cfg_val = 17'd1;
                9:       cfg_val = CNT_W'($urandom_range(0, 131071));
                10:      cfg_val = 17'd1000;
                default: cfg_val = 17'd65536;
            endcase
            write_block_count(cfg_val);
            case (p % 4)
                1:       idle_pct = 57;
                2:       idle_pct = 24;
                default: idle_pct = 0;
            endcase
            lim = (cfg_val > ADDR_LIMIT) ? ADDR_LIMIT : int'(cfg_val);
            queue_random_requests(PHASE_LEN, lim);
        end

        drain_requests();
        repeat (40) @(posedge i_clk);
        $display("%0d requests over %0d count settings: %0d ok, %0d full, %0d double frees,",
                 n_accepted, n_cfg_writes, n_allocated, n_full, n_dbl_free);
        $display("%0d out of range, %0d check errors", n_range, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
